// File: rtl/core/sjlm_pkg.sv
// Shared types, constants and constant tables of the servo joint limit mapper.
// No dependencies; every other file of the block refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package sjlm_pkg;

  // operation codes
  localparam logic [2:0] OP_SET_ANGLE      = 3'd0;
  localparam logic [2:0] OP_SET_ANGLE_DIFF = 3'd1;
  localparam logic [2:0] OP_SET_MIN        = 3'd2;
  localparam logic [2:0] OP_SET_MAX        = 3'd3;
  localparam logic [2:0] OP_SET_HOME       = 3'd4;

  // configuration register indexes (byte address = 4 * index)
  localparam int          CFG_ADDR_W        = 5;
  localparam logic [2:0]  REG_ANGLE_FLOOR   = 3'd0;
  localparam logic [2:0]  REG_ANGLE_CEILING = 3'd1;
  localparam logic [2:0]  REG_PULSE_LOW     = 3'd2;
  localparam logic [2:0]  REG_PULSE_HIGH    = 3'd3;
  localparam logic [2:0]  REG_CLOCKWISE     = 3'd4;

  // reset values
  localparam logic signed [15:0] FLOOR_RST      = -16'sd800;
  localparam logic signed [15:0] CEIL_RST       = 16'sd800;
  localparam logic [11:0]        PULSE_LOW_RST  = 12'd150;
  localparam logic [11:0]        PULSE_HIGH_RST = 12'd600;
  localparam logic               CW_RST         = 1'b1;

  // joint table select
  localparam logic [1:0] TBL_MIN  = 2'd0;
  localparam logic [1:0] TBL_MAX  = 2'd1;
  localparam logic [1:0] TBL_HOME = 2'd2;

  // joints driven directly: 90 +/- angle / 10
  localparam logic [7:0]  DIRECT_J0   = 8'd0;
  localparam logic [7:0]  DIRECT_J1   = 8'd12;
  localparam logic [11:0] DIRECT_BASE = 12'd90;
  localparam logic [15:0] DIRECT_DIV  = 16'd10;
  localparam logic [11:0] PULSE_MAX   = 12'd4095;

  // serial multiply / divide widths
  localparam int MAG_W  = 16;               // multiplicand, divisor magnitude
  localparam int MPL_W  = 12;               // multiplier magnitude
  localparam int PROD_W = MAG_W + MPL_W;    // product and quotient
  localparam int DIG    = 2;                // bits retired per cycle

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         joint;
    logic signed [15:0] angle_value;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic [4:0]         channel;
    logic [11:0]        pulse;
    logic signed [15:0] clamped_angle;
  } out_t;

  typedef struct packed {
    logic signed [15:0] angle_floor;
    logic signed [15:0] angle_ceiling;
    logic [11:0]        pulse_low;
    logic [11:0]        pulse_high;
    logic               clockwise;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_PREP,
    ST_CALC,
    ST_FINISH,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  // joint to output channel; joints past the map give channel 0
  function automatic logic [4:0] chan_of(input logic [7:0] j);
    logic [4:0] c;
    unique case (j)
      8'd0:    c = 5'd16;
      8'd1:    c = 5'd7;
      8'd2:    c = 5'd6;
      8'd3:    c = 5'd5;
      8'd4:    c = 5'd4;
      8'd5:    c = 5'd3;
      8'd6:    c = 5'd2;
      8'd7:    c = 5'd1;
      8'd8:    c = 5'd0;
      8'd9:    c = 5'd18;
      8'd10:   c = 5'd19;
      8'd11:   c = 5'd20;
      8'd12:   c = 5'd17;
      8'd13:   c = 5'd8;
      8'd14:   c = 5'd9;
      8'd15:   c = 5'd10;
      8'd16:   c = 5'd11;
      8'd17:   c = 5'd12;
      8'd18:   c = 5'd13;
      8'd19:   c = 5'd14;
      8'd20:   c = 5'd15;
      8'd21:   c = 5'd21;
      8'd22:   c = 5'd22;
      8'd23:   c = 5'd23;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  // home angle after reset
  function automatic logic signed [15:0] home_of(input logic [7:0] j);
    logic signed [15:0] h;
    unique case (j)
      8'd0:    h = -16'sd40;
      8'd1:    h = 16'sd245;
      8'd2:    h = 16'sd470;
      8'd3:    h = -16'sd100;
      8'd4:    h = -16'sd205;
      8'd5:    h = 16'sd50;
      8'd6:    h = 16'sd445;
      8'd7:    h = 16'sd245;
      8'd8:    h = -16'sd75;
      8'd12:   h = 16'sd15;
      8'd13:   h = -16'sd70;
      8'd14:   h = -16'sd390;
      8'd15:   h = 16'sd250;
      8'd16:   h = 16'sd195;
      8'd17:   h = -16'sd105;
      8'd18:   h = -16'sd510;
      8'd19:   h = -16'sd305;
      8'd20:   h = 16'sd60;
      default: h = 16'sd0;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sjlm_regs.sv
// Configuration registers on an APB-style port: floor, ceiling, pulse range, direction.
// Depends on sjlm_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module sjlm_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sjlm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output sjlm_pkg::cfg_t                        cfg
);

  sjlm_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[sjlm_pkg::CFG_ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_floor   <= sjlm_pkg::FLOOR_RST;
      cfg_r.angle_ceiling <= sjlm_pkg::CEIL_RST;
      cfg_r.pulse_low     <= sjlm_pkg::PULSE_LOW_RST;
      cfg_r.pulse_high    <= sjlm_pkg::PULSE_HIGH_RST;
      cfg_r.clockwise     <= sjlm_pkg::CW_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        sjlm_pkg::REG_ANGLE_FLOOR:   cfg_r.angle_floor   <= pwdata[15:0];
        sjlm_pkg::REG_ANGLE_CEILING: cfg_r.angle_ceiling <= pwdata[15:0];
        sjlm_pkg::REG_PULSE_LOW:     cfg_r.pulse_low     <= pwdata[11:0];
        sjlm_pkg::REG_PULSE_HIGH:    cfg_r.pulse_high    <= pwdata[11:0];
        sjlm_pkg::REG_CLOCKWISE:     cfg_r.clockwise     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sjlm_pkg::REG_ANGLE_FLOOR:   prdata = {16'd0, cfg_r.angle_floor};
      sjlm_pkg::REG_ANGLE_CEILING: prdata = {16'd0, cfg_r.angle_ceiling};
      sjlm_pkg::REG_PULSE_LOW:     prdata = {20'd0, cfg_r.pulse_low};
      sjlm_pkg::REG_PULSE_HIGH:    prdata = {20'd0, cfg_r.pulse_high};
      sjlm_pkg::REG_CLOCKWISE:     prdata = {31'd0, cfg_r.clockwise};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/sjlm_tables.sv
// Per-joint min, max and home angle memories with registered read and valid bits;
// an entry never written reads as its reset value. Depends on sjlm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sjlm_tables #(
  parameter int JOINT_COUNT = 24,
  parameter int IDX_W       = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     rd_en,
  input  wire logic [IDX_W-1:0]         rd_idx,
  input  wire logic                     wr_en,
  input  wire logic [1:0]               wr_sel,
  input  wire logic [IDX_W-1:0]         wr_idx,
  input  wire logic signed [15:0]       wr_data,
  output logic signed [15:0]            min_q,
  output logic signed [15:0]            max_q,
  output logic signed [15:0]            home_q
);

  logic signed [15:0] min_mem  [JOINT_COUNT];
  logic signed [15:0] max_mem  [JOINT_COUNT];
  logic signed [15:0] home_mem [JOINT_COUNT];

  logic [JOINT_COUNT-1:0] min_vld_r, max_vld_r, home_vld_r;
  logic                   min_hit_r, max_hit_r, home_hit_r;
  logic signed [15:0]     min_rd_r, max_rd_r, home_rd_r;
  logic [IDX_W-1:0]       rd_idx_r;

  always_ff @(posedge clk) begin
    if (wr_en && wr_sel == sjlm_pkg::TBL_MIN)  min_mem[wr_idx]  <= wr_data;
    if (wr_en && wr_sel == sjlm_pkg::TBL_MAX)  max_mem[wr_idx]  <= wr_data;
    if (wr_en && wr_sel == sjlm_pkg::TBL_HOME) home_mem[wr_idx] <= wr_data;
    if (rd_en) begin
      min_rd_r  <= min_mem[rd_idx];
      max_rd_r  <= max_mem[rd_idx];
      home_rd_r <= home_mem[rd_idx];
      rd_idx_r  <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_vld_r  <= '0;
      max_vld_r  <= '0;
      home_vld_r <= '0;
      min_hit_r  <= 1'b0;
      max_hit_r  <= 1'b0;
      home_hit_r <= 1'b0;
    end else begin
      if (wr_en && wr_sel == sjlm_pkg::TBL_MIN)  min_vld_r[wr_idx]  <= 1'b1;
      if (wr_en && wr_sel == sjlm_pkg::TBL_MAX)  max_vld_r[wr_idx]  <= 1'b1;
      if (wr_en && wr_sel == sjlm_pkg::TBL_HOME) home_vld_r[wr_idx] <= 1'b1;
      if (rd_en) begin
        min_hit_r  <= min_vld_r[rd_idx];
        max_hit_r  <= max_vld_r[rd_idx];
        home_hit_r <= home_vld_r[rd_idx];
      end
    end
  end

  assign min_q  = min_hit_r  ? min_rd_r  : sjlm_pkg::FLOOR_RST;
  assign max_q  = max_hit_r  ? max_rd_r  : sjlm_pkg::CEIL_RST;
  assign home_q = home_hit_r ? home_rd_r : sjlm_pkg::home_of(8'(rd_idx_r));

endmodule

`default_nettype wire

// File: rtl/core/sjlm_muldiv.sv
// Digit-serial unsigned multiply then divide: (mcand * mplier) / divisor,
// DIG bits per cycle through one shift register. Depends on sjlm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sjlm_muldiv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sjlm_pkg::MAG_W-1:0]    mcand,
  input  wire logic [sjlm_pkg::MPL_W-1:0]    mplier,
  input  wire logic [sjlm_pkg::MAG_W-1:0]    divisor,
  output logic                               done,
  output logic [sjlm_pkg::PROD_W-1:0]        quot
);

  localparam int MW      = sjlm_pkg::MAG_W;
  localparam int LW      = sjlm_pkg::MPL_W;
  localparam int PW      = sjlm_pkg::PROD_W;
  localparam int MUL_CYC = LW / sjlm_pkg::DIG;
  localparam int DIV_CYC = PW / sjlm_pkg::DIG;
  localparam int CNT_W   = $clog2(DIV_CYC);

  sjlm_pkg::md_state_t st_r, st_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [PW-1:0]       sr_r;       // multiplier/product, then dividend/quotient
  logic [MW-1:0]       rem_r;
  logic [MW-1:0]       mc_r;
  logic [MW-1:0]       dv_r;
  logic [PW-1:0]       mul_nxt;
  logic [PW-1:0]       div_sr_nxt;
  logic [MW-1:0]       div_rem_nxt;
  logic                last;

  assign last = (cnt_r == '0);

  // shift-add: product high part accumulates, multiplier bits leave at the bottom
  always_comb begin : mul_step
    logic [MW:0]   sum;
    logic [PW-1:0] p;
    p = sr_r;
    for (int k = 0; k < sjlm_pkg::DIG; k++) begin
      sum = {1'b0, p[PW-1:LW]} + (p[0] ? {1'b0, mc_r} : '0);
      p   = {sum, p[LW-1:1]};
    end
    mul_nxt = p;
  end

  // restoring division, quotient bits enter at the bottom
  always_comb begin : div_step
    logic [MW:0]   r2;
    logic [MW:0]   diff;
    logic [MW-1:0] r;
    logic [PW-1:0] q;
    r = rem_r;
    q = sr_r;
    for (int k = 0; k < sjlm_pkg::DIG; k++) begin
      r2   = {r, q[PW-1]};
      diff = r2 - {1'b0, dv_r};
      if (r2 >= {1'b0, dv_r}) begin
        r = diff[MW-1:0];
        q = {q[PW-2:0], 1'b1};
      end else begin
        r = r2[MW-1:0];
        q = {q[PW-2:0], 1'b0};
      end
    end
    div_sr_nxt  = q;
    div_rem_nxt = r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sjlm_pkg::MD_IDLE: if (start) st_nxt = sjlm_pkg::MD_MUL;
      sjlm_pkg::MD_MUL:  if (last)  st_nxt = sjlm_pkg::MD_DIV;
      sjlm_pkg::MD_DIV:  if (last)  st_nxt = sjlm_pkg::MD_IDLE;
      default:                      st_nxt = sjlm_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    done = (st_r == sjlm_pkg::MD_DIV) && last;
    quot = sr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= sjlm_pkg::MD_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        sjlm_pkg::MD_IDLE: if (start) cnt_r <= CNT_W'(MUL_CYC - 1);
        sjlm_pkg::MD_MUL:  cnt_r <= last ? CNT_W'(DIV_CYC - 1) : cnt_r - 1'b1;
        sjlm_pkg::MD_DIV:  if (!last) cnt_r <= cnt_r - 1'b1;
        default:           cnt_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      sjlm_pkg::MD_IDLE: begin
        if (start) begin
          mc_r  <= mcand;
          dv_r  <= divisor;
          sr_r  <= {{MW{1'b0}}, mplier};
          rem_r <= '0;
        end
      end
      sjlm_pkg::MD_MUL: begin
        sr_r <= mul_nxt;
      end
      sjlm_pkg::MD_DIV: begin
        sr_r  <= div_sr_nxt;
        rem_r <= div_rem_nxt;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/servo_joint_limit_mapper.sv
// Servo joint limit mapper, top level: command sequencer, result register, assertions.
// Depends on sjlm_pkg, sjlm_regs, sjlm_tables and sjlm_muldiv.
//
// Usage:
//   Input channel in_valid/in_stall/in_data (sjlm_pkg::in_t) carries one command item:
//   operation, joint, angle_value. Each item gives exactly one result item on
//   out_valid/out_stall/out_data (sjlm_pkg::out_t).
//   One item is worked on at a time; in_stall is high from acceptance until the
//   result moves into the output register.
//   Limit commands and refusals pass through the READ, CHECK and DONE states after
//   acceptance; angle commands pass through READ, CHECK, PREP, CALC, FINISH and DONE,
//   with CALC waiting on the serial multiply and then divide, two bits per cycle.
//   A result waiting under out_stall does not block the next item; that item
//   finishes its work and then waits until the output register is taken.
//   Configuration registers sit on the APB-style port at byte address 4 * index;
//   write them only while no item is in flight.
//   Reset (rst_n low, synchronous) restores register defaults and marks every
//   table entry as holding its reset limit or home angle; no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module servo_joint_limit_mapper #(
  parameter int JOINT_COUNT = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire sjlm_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output sjlm_pkg::out_t                        out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sjlm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready
);

  localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int MW    = sjlm_pkg::MAG_W;
  localparam int PW    = sjlm_pkg::PROD_W;

  sjlm_pkg::cfg_t       cfg;
  sjlm_pkg::ctl_state_t state_r, state_nxt;
  sjlm_pkg::in_t        cmd_r;
  sjlm_pkg::out_t       res_r, out_r, check_res;
  logic                 out_valid_r;

  logic signed [15:0]   a_r;
  logic                 neg_r, zero_r;
  logic [11:0]          base_r;

  // table port
  logic                 rd_en, tbl_wr_en;
  logic [1:0]           tbl_wr_sel;
  logic signed [15:0]   min_q, max_q, home_q;

  // serial unit
  logic                 md_start, md_done;
  logic [MW-1:0]        md_mcand, md_divisor;
  logic [11:0]          md_mplier;
  logic [PW-1:0]        md_quot;

  logic                 accept, out_load;
  logic                 joint_ok, op_ok, is_angle, is_direct, limit_ok;
  logic [IDX_W-1:0]     jidx;
  logic signed [15:0]   v;

  sjlm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sjlm_tables #(
    .JOINT_COUNT (JOINT_COUNT),
    .IDX_W       (IDX_W)
  ) u_tables (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_idx  (jidx),
    .wr_en   (tbl_wr_en),
    .wr_sel  (tbl_wr_sel),
    .wr_idx  (jidx),
    .wr_data (v),
    .min_q   (min_q),
    .max_q   (max_q),
    .home_q  (home_q)
  );

  sjlm_muldiv u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (md_start),
    .mcand   (md_mcand),
    .mplier  (md_mplier),
    .divisor (md_divisor),
    .done    (md_done),
    .quot    (md_quot)
  );

  // ---------------- command decode ----------------
  assign v         = cmd_r.angle_value;
  assign jidx      = cmd_r.joint[IDX_W-1:0];
  assign joint_ok  = cmd_r.joint < 8'(JOINT_COUNT);
  assign op_ok     = cmd_r.operation <= sjlm_pkg::OP_SET_HOME;
  assign is_angle  = (cmd_r.operation == sjlm_pkg::OP_SET_ANGLE) ||
                     (cmd_r.operation == sjlm_pkg::OP_SET_ANGLE_DIFF);
  assign is_direct = (cmd_r.joint == sjlm_pkg::DIRECT_J0) ||
                     (cmd_r.joint == sjlm_pkg::DIRECT_J1);

  // ---------------- check stage: clamp and limit checks ----------------
  logic signed [16:0] a_sum, min17, max17;
  logic signed [15:0] a_clamp;

  always_comb begin
    min17 = {min_q[15], min_q};
    max17 = {max_q[15], max_q};
    a_sum = {v[15], v};
    if (cmd_r.operation == sjlm_pkg::OP_SET_ANGLE_DIFF) begin
      a_sum = {v[15], v} + {home_q[15], home_q};
    end
    priority if (a_sum < min17) a_clamp = min_q;
    else if (a_sum > max17)     a_clamp = max_q;
    else                        a_clamp = a_sum[15:0];
  end

  always_comb begin
    limit_ok   = 1'b0;
    tbl_wr_sel = sjlm_pkg::TBL_MIN;
    unique case (cmd_r.operation)
      sjlm_pkg::OP_SET_MIN: begin
        limit_ok   = (v < max_q) && (v >= cfg.angle_floor);
        tbl_wr_sel = sjlm_pkg::TBL_MIN;
      end
      sjlm_pkg::OP_SET_MAX: begin
        limit_ok   = (v > min_q) && (v <= cfg.angle_ceiling);
        tbl_wr_sel = sjlm_pkg::TBL_MAX;
      end
      sjlm_pkg::OP_SET_HOME: begin
        limit_ok   = (v >= min_q) && (v <= max_q);
        tbl_wr_sel = sjlm_pkg::TBL_HOME;
      end
      default: ;
    endcase
  end

  always_comb begin
    check_res = '0;
    if (joint_ok && op_ok) begin
      check_res.accepted      = is_angle ? 1'b1 : limit_ok;
      check_res.channel       = sjlm_pkg::chan_of(cmd_r.joint);
      check_res.clamped_angle = is_angle ? a_clamp : v;
    end
  end

  // ---------------- prep stage: operands for the serial unit ----------------
  logic [11:0]        lo, hi;
  logic signed [12:0] dpulse, dpulse_n;
  logic signed [16:0] span, span_n, da, da_n;
  logic signed [15:0] a_n;
  logic [11:0]        dp_mag;
  logic [MW-1:0]      span_mag, da_mag, a_mag;
  logic               prep_neg, prep_zero;
  logic [11:0]        prep_base;

  always_comb begin
    lo       = cfg.clockwise ? cfg.pulse_low  : cfg.pulse_high;
    hi       = cfg.clockwise ? cfg.pulse_high : cfg.pulse_low;
    dpulse   = {1'b0, hi} - {1'b0, lo};
    dpulse_n = -dpulse;
    dp_mag   = dpulse[12] ? dpulse_n[11:0] : dpulse[11:0];
    span     = {cfg.angle_ceiling[15], cfg.angle_ceiling} -
               {cfg.angle_floor[15], cfg.angle_floor};
    span_n   = -span;
    span_mag = span[16] ? span_n[MW-1:0] : span[MW-1:0];
    da       = {a_r[15], a_r} - {cfg.angle_floor[15], cfg.angle_floor};
    da_n     = -da;
    da_mag   = da[16] ? da_n[MW-1:0] : da[MW-1:0];
    a_n      = -a_r;
    a_mag    = a_r[15] ? a_n : a_r;
    if (is_direct) begin
      md_mcand   = a_mag;
      md_mplier  = 12'd1;
      md_divisor = sjlm_pkg::DIRECT_DIV;
      prep_neg   = a_r[15] ^ ~cfg.clockwise;
      prep_base  = sjlm_pkg::DIRECT_BASE;
      prep_zero  = 1'b0;
    end else begin
      md_mcand   = da_mag;
      md_mplier  = dp_mag;
      md_divisor = span_mag;
      prep_neg   = da[16] ^ dpulse[12] ^ span[16];
      prep_base  = lo;
      prep_zero  = (span == '0);
    end
  end

  // ---------------- finish stage: offset and saturate ----------------
  logic [PW-1:0] q_eff;
  logic [PW:0]   psum;
  logic [11:0]   fin_pulse;

  always_comb begin
    q_eff = zero_r ? '0 : md_quot;
    psum  = {1'b0, q_eff} + (PW+1)'(base_r);
    if (neg_r) begin
      if (q_eff > PW'(base_r)) fin_pulse = 12'd0;
      else                     fin_pulse = base_r - q_eff[11:0];
    end else begin
      if (psum > (PW+1)'(sjlm_pkg::PULSE_MAX)) fin_pulse = sjlm_pkg::PULSE_MAX;
      else                                    fin_pulse = psum[11:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sjlm_pkg::ST_IDLE:   if (in_valid) state_nxt = sjlm_pkg::ST_READ;
      sjlm_pkg::ST_READ:   state_nxt = sjlm_pkg::ST_CHECK;
      sjlm_pkg::ST_CHECK: begin
        if (joint_ok && op_ok && is_angle) state_nxt = sjlm_pkg::ST_PREP;
        else                               state_nxt = sjlm_pkg::ST_DONE;
      end
      sjlm_pkg::ST_PREP:   state_nxt = sjlm_pkg::ST_CALC;
      sjlm_pkg::ST_CALC:   if (md_done) state_nxt = sjlm_pkg::ST_FINISH;
      sjlm_pkg::ST_FINISH: state_nxt = sjlm_pkg::ST_DONE;
      sjlm_pkg::ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = sjlm_pkg::ST_IDLE;
      default:             state_nxt = sjlm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != sjlm_pkg::ST_IDLE);
    accept    = in_valid && !in_stall;
    rd_en     = (state_r == sjlm_pkg::ST_READ) && joint_ok;
    tbl_wr_en = (state_r == sjlm_pkg::ST_CHECK) && joint_ok && !is_angle && limit_ok;
    md_start  = (state_r == sjlm_pkg::ST_PREP);
    out_load  = (state_r == sjlm_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sjlm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cmd_r <= in_data;
    if (state_r == sjlm_pkg::ST_CHECK) begin
      res_r <= check_res;
      a_r   <= a_clamp;
    end
    if (state_r == sjlm_pkg::ST_PREP) begin
      neg_r  <= prep_neg;
      zero_r <= prep_zero;
      base_r <= prep_base;
    end
    if (state_r == sjlm_pkg::ST_FINISH) res_r.pulse <= fin_pulse;
    if (out_load) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- assertions ----------------
  a_refused_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted || out_data.pulse == 12'd0))
    else $error("refused item carries a pulse value");

  a_write_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr_en |-> (state_r == sjlm_pkg::ST_CHECK) && !is_angle)
    else $error("table written outside the check step");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> (state_r == sjlm_pkg::ST_CALC))
    else $error("serial unit finished while sequencer not waiting");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall && (state_r == sjlm_pkg::ST_READ))
    else $error("sequencer not busy after taking an item");

endmodule

`default_nettype wire
